>>> hw/rtl/tube_mesh_tessellator_assert.svh
// ----------------------------------------------------------------------------
// Tube tessellator assertion macros
// Shared property forms for the tessellator checks.
// ----------------------------------------------------------------------------
`ifndef TUBE_MESH_TESSELLATOR_ASSERT_SVH
`define TUBE_MESH_TESSELLATOR_ASSERT_SVH

// same-cycle implication
`define TMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tessellator check failed");

// next-cycle implication
`define TMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tessellator check failed");

`endif

>>> hw/rtl/tmt_pkg.sv
// ----------------------------------------------------------------------------
// Tube tessellator package
// Item types, register indexes, CORDIC constants and the vertex order table.
// ----------------------------------------------------------------------------
package tmt_pkg;

  typedef enum logic [1:0] {
    KIND_TOP,
    KIND_SIDE,
    KIND_BOTTOM
  } kind_t;

  typedef enum logic [2:0] {
    REG_OUTER_RADIUS,
    REG_INNER_RADIUS,
    REG_TUBE_HEIGHT,
    REG_SLICE_COUNT,
    REG_STACK_COUNT
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] ring_index;
    logic [9:0]  slice_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic               last_vertex;
  } vtx_t;

  localparam int CNT_W    = 11;
  localparam int DATA_W   = 16;
  localparam int YDIV_W   = 12;
  localparam int YNUM_W   = 16;
  localparam int PDIV_W   = 11;
  localparam int PNUM_W   = 43;
  localparam int PHASE_W  = 32;
  localparam int TRIG_W   = 34;
  localparam int PROD_W   = 51;

  localparam logic signed [15:0]     ONE14 = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN30 = 34'sd652032874;

  localparam logic [TRIG_W-1:0] ATAN_TURNS [24] = '{
    34'h020000000, 34'h012E4051D, 34'h009FB385B, 34'h0051111D4, 34'h0028B0D43,
    34'h00145D7E1, 34'h000A2F61E, 34'h000517C55, 34'h00028BE53, 34'h000145F2F,
    34'h0000A2F98, 34'h0000517CC, 34'h000028BE6, 34'h0000145F3, 34'h000000A2F9,
    34'h00000517C, 34'h0000028BE, 34'h00000145F, 34'h000000A2F, 34'h000000517,
    34'h00000028B, 34'h000000145, 34'h0000000A2, 34'h000000051
  };

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] y_lo;
    logic signed [15:0] y_hi;
    logic signed [15:0] s14_a0;
    logic signed [15:0] c14_a0;
    logic signed [15:0] s14_a1;
    logic signed [15:0] c14_a1;
    logic signed [15:0] px_o0;
    logic signed [15:0] px_o1;
    logic signed [15:0] px_i0;
    logic signed [15:0] px_i1;
    logic signed [15:0] pz_o0;
    logic signed [15:0] pz_o1;
    logic signed [15:0] pz_i0;
    logic signed [15:0] pz_i1;
  } rec_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] vtx_idx;
  } emit_status_t;

  typedef struct packed {
    logic outer;
    logic ang1;
    logic hi;
    logic u1;
    logic v1;
  } vsel_t;

  function automatic vsel_t vtx_sel(kind_t kind, logic [3:0] idx);
    vsel_t s;
    s = '0;
    unique case (kind)
      KIND_TOP: begin
        unique case (idx)
          4'd0:    s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b1};
          4'd1:    s = '{outer: 1'b0, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd2:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b1, v1: 1'b0};
          4'd3:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b1, v1: 1'b0};
          4'd4:    s = '{outer: 1'b1, ang1: 1'b1, hi: 1'b0, u1: 1'b1, v1: 1'b1};
          default: s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b1};
        endcase
      end
      KIND_BOTTOM: begin
        unique case (idx)
          4'd0:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b1, v1: 1'b0};
          4'd1:    s = '{outer: 1'b0, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd2:    s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b1};
          4'd3:    s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b1};
          4'd4:    s = '{outer: 1'b1, ang1: 1'b1, hi: 1'b0, u1: 1'b1, v1: 1'b1};
          default: s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b1, v1: 1'b0};
        endcase
      end
      default: begin
        unique case (idx)
          4'd0:    s = '{outer: 1'b1, ang1: 1'b1, hi: 1'b1, u1: 1'b0, v1: 1'b0};
          4'd1:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b1, u1: 1'b0, v1: 1'b0};
          4'd2:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd3:    s = '{outer: 1'b1, ang1: 1'b1, hi: 1'b1, u1: 1'b0, v1: 1'b0};
          4'd4:    s = '{outer: 1'b1, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd5:    s = '{outer: 1'b1, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd6:    s = '{outer: 1'b0, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd7:    s = '{outer: 1'b0, ang1: 1'b0, hi: 1'b1, u1: 1'b0, v1: 1'b0};
          4'd8:    s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b1, u1: 1'b0, v1: 1'b0};
          4'd9:    s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          4'd10:   s = '{outer: 1'b0, ang1: 1'b0, hi: 1'b0, u1: 1'b0, v1: 1'b0};
          default: s = '{outer: 1'b0, ang1: 1'b1, hi: 1'b1, u1: 1'b0, v1: 1'b0};
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/tmt_stream_if.sv
// ----------------------------------------------------------------------------
// Tube tessellator stream channel
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface tmt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/tmt_div_cell.sv
// ----------------------------------------------------------------------------
// Tube tessellator divider cell
// One restoring division step: take in one dividend bit, emit one quotient bit.
// ----------------------------------------------------------------------------
module tmt_div_cell #(
  parameter int DW     = 12,
  parameter int NW     = 16,
  parameter int QW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [DW-1:0]     divisor,
  input  logic [DW-1:0]     rem_in,
  input  logic [NW-1:0]     num_in,
  input  logic [QW-1:0]     quo_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [DW-1:0]     rem_out,
  output logic [NW-1:0]     num_out,
  output logic [QW-1:0]     quo_out,
  output logic [SIDE_W-1:0] side_out
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_in, num_in[NW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_out  <= {num_in[NW-2:0], 1'b0};
      quo_out  <= {quo_in[QW-2:0], ge};
      side_out <= side_in;
    end
  end
endmodule

>>> hw/rtl/tmt_cordic_cell.sv
// ----------------------------------------------------------------------------
// Tube tessellator CORDIC cell
// One rotation step of the sine/cosine chain.
// ----------------------------------------------------------------------------
module tmt_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [tmt_pkg::TRIG_W-1:0] x_in,
  input  logic signed [tmt_pkg::TRIG_W-1:0] y_in,
  input  logic signed [tmt_pkg::TRIG_W-1:0] z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic signed [tmt_pkg::TRIG_W-1:0] x_out,
  output logic signed [tmt_pkg::TRIG_W-1:0] y_out,
  output logic signed [tmt_pkg::TRIG_W-1:0] z_out,
  output logic [SIDE_W-1:0]               side_out
);
  import tmt_pkg::*;

  localparam logic signed [TRIG_W-1:0] ATAN = $signed(ATAN_TURNS[STEP]);

  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!z_in[TRIG_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end
      side_out <= side_in;
    end
  end
endmodule

>>> hw/rtl/tmt_emitter.sv
// ----------------------------------------------------------------------------
// Tube tessellator vertex emitter
// Hold one cell record and hand out its vertices through an output register.
// ----------------------------------------------------------------------------
module tmt_emitter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid_in,
  input  tmt_pkg::rec_t         rec_in,
  output logic                  take,
  output tmt_pkg::emit_status_t status,
  tmt_stream_if.source          verts
);
  import tmt_pkg::*;

  logic       rec_valid;
  rec_t       rec;
  logic [3:0] idx;
  logic       out_valid;
  vtx_t       out_item;
  vtx_t       vtx;
  vsel_t      sel;
  logic [3:0] last_idx;
  logic       last;
  logic       load;

  assign sel      = vtx_sel(rec.kind, idx);
  assign last_idx = (rec.kind == KIND_SIDE) ? 4'd11 : 4'd5;
  assign last     = idx == last_idx;
  assign load     = rec_valid && (!out_valid || verts.ready);
  assign take     = !rec_valid || (load && last);

  always_comb begin
    vtx = '0;
    unique case ({sel.outer, sel.ang1})
      2'b00:   begin vtx.pos_x = rec.px_i0; vtx.pos_z = rec.pz_i0; end
      2'b01:   begin vtx.pos_x = rec.px_i1; vtx.pos_z = rec.pz_i1; end
      2'b10:   begin vtx.pos_x = rec.px_o0; vtx.pos_z = rec.pz_o0; end
      default: begin vtx.pos_x = rec.px_o1; vtx.pos_z = rec.pz_o1; end
    endcase
    vtx.pos_y = sel.hi ? rec.y_hi : rec.y_lo;
    unique case (rec.kind)
      KIND_TOP: begin
        vtx.norm_y = ONE14;
      end
      KIND_BOTTOM: begin
        vtx.norm_y = -ONE14;
      end
      default: begin
        vtx.norm_x = sel.ang1 ? rec.s14_a1 : rec.s14_a0;
        vtx.norm_z = sel.ang1 ? rec.c14_a1 : rec.c14_a0;
        if (!sel.outer) begin
          vtx.norm_x = -vtx.norm_x;
          vtx.norm_z = -vtx.norm_z;
        end
      end
    endcase
    vtx.tex_u       = sel.u1 ? ONE14[14:0] : 15'd0;
    vtx.tex_v       = sel.v1 ? ONE14[14:0] : 15'd0;
    vtx.last_vertex = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (verts.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        idx <= last ? 4'd0 : idx + 4'd1;
      end
      if (take) begin
        rec_valid <= rec_valid_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= vtx;
    end
    if (take) begin
      rec <= rec_in;
    end
  end

  assign verts.valid    = out_valid;
  assign verts.payload  = out_item;
  assign status.busy    = rec_valid;
  assign status.vtx_idx = idx;
endmodule

>>> hw/rtl/tube_mesh_tessellator.sv
// ----------------------------------------------------------------------------
// Hollow tube tessellator
// Turn one (ring, slice) cell into the triangle vertices of a hollow tube.
// ----------------------------------------------------------------------------
// Channel  Dir  Item                          Handshake
// cells    in   ring_index, slice_index        valid/ready
// verts    out  position, normal, tex, last    valid/ready
// cfg      in   register index and data        write enable, no wait
//
// A side cell gives twelve vertices and a cap six, one a cycle through the
// output register while the output is not stalled; the emitter sets it.
// On the way from a taken cell to its first vertex, the height and phase
// dividers and the CORDIC are chains of one-step cells.
// Reset clears valid state and loads the register defaults.
// An output stall holds the whole chain; a new cell is taken while the last
// vertex of the previous one is handed over.
// ----------------------------------------------------------------------------
module tube_mesh_tessellator #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  tmt_stream_if.sink   cells,
  tmt_stream_if.source verts
);
  import tmt_pkg::*;

  localparam int LAT = 3 + YNUM_W + PNUM_W + CORDIC_STEPS + 2;

  logic [DATA_W-1:0] outer_radius, inner_radius, tube_height;
  logic [CNT_W-1:0]  slice_count, stack_count;
  logic [CNT_W-1:0]  s_eff, st_eff;

  logic         adv;
  logic         in_ok;
  logic [LAT-1:0] vld;
  emit_status_t st;

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (32'(c) > MAX_DIVISIONS) r = CNT_W'(MAX_DIVISIONS);
    return r;
  endfunction

  function automatic logic signed [15:0] y_sat(logic neg, logic [15:0] q);
    logic signed [16:0] t;
    t = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (t > 17'sd32767) t = 17'sd32767;
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] t14(logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] t;
    t = (v + TRIG_W'(32768)) >>> 16;
    if (t > TRIG_W'(16384)) t = TRIG_W'(16384);
    else if (t < -TRIG_W'(16384)) t = -TRIG_W'(16384);
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] pos_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + (PROD_W'(1) <<< 29)) >>> 30;
    if (t > PROD_W'(32767)) t = PROD_W'(32767);
    else if (t < -PROD_W'(32768)) t = -PROD_W'(32768);
    return t[15:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_radius <= 16'd256;
      inner_radius <= 16'd128;
      tube_height  <= 16'd512;
      slice_count  <= 11'd16;
      stack_count  <= 11'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OUTER_RADIUS: outer_radius <= cfg_data;
        REG_INNER_RADIUS: inner_radius <= cfg_data;
        REG_TUBE_HEIGHT:  tube_height  <= cfg_data;
        REG_SLICE_COUNT:  slice_count  <= cfg_data[CNT_W-1:0];
        REG_STACK_COUNT:  stack_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_eff  = eff_count(slice_count);
  assign st_eff = eff_count(stack_count);

  // input stage
  kind_t            a_kind, b_kind, c_kind;
  logic [CNT_W-1:0] a_k0, a_k1, a_ka, a_kb, b_k0, b_k1, c_k0, c_k1;
  kind_t            kind_next;
  logic [CNT_W-1:0] ka_next, kb_next;
  logic [CNT_W-1:0] ring;

  assign ring        = cells.payload.ring_index;
  assign cells.ready = adv;
  assign in_ok       = cells.valid && adv && (ring <= st_eff + CNT_W'(1));

  always_comb begin
    if (ring == '0) begin
      kind_next = KIND_TOP;
      ka_next   = '0;
      kb_next   = '0;
    end else if (ring == st_eff + CNT_W'(1)) begin
      kind_next = KIND_BOTTOM;
      ka_next   = st_eff;
      kb_next   = st_eff;
    end else begin
      kind_next = KIND_SIDE;
      ka_next   = ring;
      kb_next   = ring - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_ok};
    end
  end

  logic signed [12:0] diff_a, diff_b;
  logic signed [29:0] b_prod_a, b_prod_b;
  logic [29:0]        mag_a, mag_b;
  logic [26:0]        c_d_a, c_d_b;
  logic               c_neg_a, c_neg_b;

  assign diff_a = $signed({2'b00, st_eff}) - $signed({1'b0, a_ka, 1'b0});
  assign diff_b = $signed({2'b00, st_eff}) - $signed({1'b0, a_kb, 1'b0});
  assign mag_a  = b_prod_a[29] ? 30'(-b_prod_a) : 30'(b_prod_a);
  assign mag_b  = b_prod_b[29] ? 30'(-b_prod_b) : 30'(b_prod_b);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind   <= kind_next;
      a_k0     <= {1'b0, cells.payload.slice_index};
      a_k1     <= {1'b0, cells.payload.slice_index} + CNT_W'(1);
      a_ka     <= ka_next;
      a_kb     <= kb_next;
      b_kind   <= a_kind;
      b_k0     <= a_k0;
      b_k1     <= a_k1;
      b_prod_a <= $signed({1'b0, tube_height}) * diff_a;
      b_prod_b <= $signed({1'b0, tube_height}) * diff_b;
      c_kind   <= b_kind;
      c_k0     <= b_k0;
      c_k1     <= b_k1;
      c_d_a    <= mag_a[26:0] + {16'd0, st_eff};
      c_d_b    <= mag_b[26:0] + {16'd0, st_eff};
      c_neg_a  <= b_prod_a[29];
      c_neg_b  <= b_prod_b[29];
    end
  end

  // height divider chain
  localparam int YSA_W = 2 + 2 * CNT_W + 1;
  logic [YDIV_W-1:0] y_div;
  logic [YDIV_W-1:0] yr_a [YNUM_W+1];
  logic [YDIV_W-1:0] yr_b [YNUM_W+1];
  logic [YNUM_W-1:0] yn_a [YNUM_W+1];
  logic [YNUM_W-1:0] yn_b [YNUM_W+1];
  logic [YNUM_W-1:0] yq_a [YNUM_W+1];
  logic [YNUM_W-1:0] yq_b [YNUM_W+1];
  logic [YSA_W-1:0]  ys_a [YNUM_W+1];
  logic              ys_b [YNUM_W+1];

  assign y_div   = {st_eff, 1'b0};
  assign yr_a[0] = {1'b0, c_d_a[26:16]};
  assign yr_b[0] = {1'b0, c_d_b[26:16]};
  assign yn_a[0] = c_d_a[15:0];
  assign yn_b[0] = c_d_b[15:0];
  assign yq_a[0] = '0;
  assign yq_b[0] = '0;
  assign ys_a[0] = {c_kind, c_k0, c_k1, c_neg_a};
  assign ys_b[0] = c_neg_b;

  for (genvar j = 0; j < YNUM_W; j++) begin : g_ydiv
    tmt_div_cell #(.DW(YDIV_W), .NW(YNUM_W), .QW(YNUM_W), .SIDE_W(YSA_W)) u_a (
      .clk(clk), .adv(adv), .divisor(y_div),
      .rem_in(yr_a[j]), .num_in(yn_a[j]), .quo_in(yq_a[j]), .side_in(ys_a[j]),
      .rem_out(yr_a[j+1]), .num_out(yn_a[j+1]), .quo_out(yq_a[j+1]),
      .side_out(ys_a[j+1])
    );
    tmt_div_cell #(.DW(YDIV_W), .NW(YNUM_W), .QW(YNUM_W), .SIDE_W(1)) u_b (
      .clk(clk), .adv(adv), .divisor(y_div),
      .rem_in(yr_b[j]), .num_in(yn_b[j]), .quo_in(yq_b[j]), .side_in(ys_b[j]),
      .rem_out(yr_b[j+1]), .num_out(yn_b[j+1]), .quo_out(yq_b[j+1]),
      .side_out(ys_b[j+1])
    );
  end

  // phase divider chain
  localparam int PSA_W = 2 + 16;
  kind_t             yk;
  logic [CNT_W-1:0]  yk0, yk1;
  logic              yneg_a;
  logic [PDIV_W-1:0] pr_a [PNUM_W+1];
  logic [PDIV_W-1:0] pr_b [PNUM_W+1];
  logic [PNUM_W-1:0] pn_a [PNUM_W+1];
  logic [PNUM_W-1:0] pn_b [PNUM_W+1];
  logic [PHASE_W-1:0] pq_a [PNUM_W+1];
  logic [PHASE_W-1:0] pq_b [PNUM_W+1];
  logic [PSA_W-1:0]  ps_a [PNUM_W+1];
  logic [15:0]       ps_b [PNUM_W+1];

  assign {yk, yk0, yk1, yneg_a} = ys_a[YNUM_W];
  assign pr_a[0] = '0;
  assign pr_b[0] = '0;
  assign pn_a[0] = {yk0, 22'd0, s_eff[CNT_W-1:1]};
  assign pn_b[0] = {yk1, 22'd0, s_eff[CNT_W-1:1]};
  assign pq_a[0] = '0;
  assign pq_b[0] = '0;
  assign ps_a[0] = {yk, y_sat(yneg_a, yq_a[YNUM_W])};
  assign ps_b[0] = y_sat(ys_b[YNUM_W], yq_b[YNUM_W]);

  for (genvar j = 0; j < PNUM_W; j++) begin : g_pdiv
    tmt_div_cell #(.DW(PDIV_W), .NW(PNUM_W), .QW(PHASE_W), .SIDE_W(PSA_W)) u_a (
      .clk(clk), .adv(adv), .divisor(s_eff),
      .rem_in(pr_a[j]), .num_in(pn_a[j]), .quo_in(pq_a[j]), .side_in(ps_a[j]),
      .rem_out(pr_a[j+1]), .num_out(pn_a[j+1]), .quo_out(pq_a[j+1]),
      .side_out(ps_a[j+1])
    );
    tmt_div_cell #(.DW(PDIV_W), .NW(PNUM_W), .QW(PHASE_W), .SIDE_W(16)) u_b (
      .clk(clk), .adv(adv), .divisor(s_eff),
      .rem_in(pr_b[j]), .num_in(pn_b[j]), .quo_in(pq_b[j]), .side_in(ps_b[j]),
      .rem_out(pr_b[j+1]), .num_out(pn_b[j+1]), .quo_out(pq_b[j+1]),
      .side_out(ps_b[j+1])
    );
  end

  // CORDIC chain
  localparam int CSA_W = PSA_W + 1;
  logic [PHASE_W-1:0]       ph_a, ph_b;
  logic                     flip_a, flip_b;
  logic signed [TRIG_W-1:0] cx_a [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cy_a [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cz_a [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cx_b [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cy_b [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cz_b [CORDIC_STEPS+1];
  logic [CSA_W-1:0]         cs_a [CORDIC_STEPS+1];
  logic [16:0]              cs_b [CORDIC_STEPS+1];

  assign ph_a    = pq_a[PNUM_W];
  assign ph_b    = pq_b[PNUM_W];
  assign flip_a  = ph_a[31] ^ ph_a[30];
  assign flip_b  = ph_b[31] ^ ph_b[30];
  assign cx_a[0] = CORDIC_GAIN30;
  assign cx_b[0] = CORDIC_GAIN30;
  assign cy_a[0] = '0;
  assign cy_b[0] = '0;
  assign cz_a[0] = TRIG_W'($signed({ph_a[31] ^ flip_a, ph_a[30:0]}));
  assign cz_b[0] = TRIG_W'($signed({ph_b[31] ^ flip_b, ph_b[30:0]}));
  assign cs_a[0] = {ps_a[PNUM_W], flip_a};
  assign cs_b[0] = {ps_b[PNUM_W], flip_b};

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    tmt_cordic_cell #(.STEP(j), .SIDE_W(CSA_W)) u_a (
      .clk(clk), .adv(adv),
      .x_in(cx_a[j]), .y_in(cy_a[j]), .z_in(cz_a[j]), .side_in(cs_a[j]),
      .x_out(cx_a[j+1]), .y_out(cy_a[j+1]), .z_out(cz_a[j+1]), .side_out(cs_a[j+1])
    );
    tmt_cordic_cell #(.STEP(j), .SIDE_W(17)) u_b (
      .clk(clk), .adv(adv),
      .x_in(cx_b[j]), .y_in(cy_b[j]), .z_in(cz_b[j]), .side_in(cs_b[j]),
      .x_out(cx_b[j+1]), .y_out(cy_b[j+1]), .z_out(cz_b[j+1]), .side_out(cs_b[j+1])
    );
  end

  // trig finish, scaling and rounding
  kind_t                    ck;
  logic signed [15:0]       cylo, cyhi;
  logic                     cflip_a, cflip_b;
  logic signed [TRIG_W-1:0] fs_a, fc_a, fs_b, fc_b;

  assign {ck, cylo, cflip_a} = cs_a[CORDIC_STEPS];
  assign {cyhi, cflip_b}     = cs_b[CORDIC_STEPS];
  assign fc_a = cflip_a ? -cx_a[CORDIC_STEPS] : cx_a[CORDIC_STEPS];
  assign fs_a = cflip_a ? -cy_a[CORDIC_STEPS] : cy_a[CORDIC_STEPS];
  assign fc_b = cflip_b ? -cx_b[CORDIC_STEPS] : cx_b[CORDIC_STEPS];
  assign fs_b = cflip_b ? -cy_b[CORDIC_STEPS] : cy_b[CORDIC_STEPS];

  kind_t                    p1_kind, p2_kind;
  logic signed [15:0]       p1_ylo, p1_yhi, p2_ylo, p2_yhi;
  logic signed [TRIG_W-1:0] p1_s0, p1_c0, p1_s1, p1_c1;
  logic signed [15:0]       p1_n0s, p1_n0c, p1_n1s, p1_n1c;
  logic signed [15:0]       p2_n0s, p2_n0c, p2_n1s, p2_n1c;
  logic signed [PROD_W-1:0] x_o0, x_o1, x_i0, x_i1, z_o0, z_o1, z_i0, z_i1;
  logic signed [16:0]       ro_s, ri_s;
  rec_t                     rec_next;

  assign ro_s = $signed({1'b0, outer_radius});
  assign ri_s = $signed({1'b0, inner_radius});

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind <= ck;
      p1_ylo  <= cylo;
      p1_yhi  <= cyhi;
      p1_s0   <= fs_a;
      p1_c0   <= fc_a;
      p1_s1   <= fs_b;
      p1_c1   <= fc_b;
      p1_n0s  <= t14(fs_a);
      p1_n0c  <= t14(fc_a);
      p1_n1s  <= t14(fs_b);
      p1_n1c  <= t14(fc_b);
      p2_kind <= p1_kind;
      p2_ylo  <= p1_ylo;
      p2_yhi  <= p1_yhi;
      p2_n0s  <= p1_n0s;
      p2_n0c  <= p1_n0c;
      p2_n1s  <= p1_n1s;
      p2_n1c  <= p1_n1c;
      x_o0    <= ro_s * p1_s0;
      x_o1    <= ro_s * p1_s1;
      x_i0    <= ri_s * p1_s0;
      x_i1    <= ri_s * p1_s1;
      z_o0    <= ro_s * p1_c0;
      z_o1    <= ro_s * p1_c1;
      z_i0    <= ri_s * p1_c0;
      z_i1    <= ri_s * p1_c1;
    end
  end

  always_comb begin
    rec_next.kind   = p2_kind;
    rec_next.y_lo   = p2_ylo;
    rec_next.y_hi   = p2_yhi;
    rec_next.s14_a0 = p2_n0s;
    rec_next.c14_a0 = p2_n0c;
    rec_next.s14_a1 = p2_n1s;
    rec_next.c14_a1 = p2_n1c;
    rec_next.px_o0  = pos_sat(x_o0);
    rec_next.px_o1  = pos_sat(x_o1);
    rec_next.px_i0  = pos_sat(x_i0);
    rec_next.px_i1  = pos_sat(x_i1);
    rec_next.pz_o0  = pos_sat(z_o0);
    rec_next.pz_o1  = pos_sat(z_o1);
    rec_next.pz_i0  = pos_sat(z_i0);
    rec_next.pz_i1  = pos_sat(z_i1);
  end

  tmt_emitter u_emit (
    .clk(clk),
    .rst(rst),
    .rec_valid_in(vld[LAT-1]),
    .rec_in(rec_next),
    .take(adv),
    .status(st),
    .verts(verts)
  );

`include "tube_mesh_tessellator_assert.svh"

  `TMT_ASSERT_IMP(a_idx_range, st.busy, st.vtx_idx <= 4'd11)
  `TMT_ASSERT_IMP(a_idx_idle, !st.busy, st.vtx_idx == 4'd0)
  `TMT_ASSERT_NEXT(a_rec_hold, st.busy && !adv, st.busy)
  `TMT_ASSERT_IMP(a_ready_free, !st.busy, cells.ready)

endmodule

>>> dv/tb_tube_mesh_tessellator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hollow tube tessellator testbench
// Drives (ring, slice) cells with random idling on both channels, rebuilds
// the vertex list of each cell from the register settings, and checks every
// vertex in order against the list. Covers defaults, count and radius
// extremes, rings past the bottom cap, and slices past the count.
// ----------------------------------------------------------------------------
module tb_tube_mesh_tessellator;
  import tmt_pkg::*;

  typedef struct {
    longint s30;
    longint c30;
    longint s14;
    longint c14;
  } angle_t;

  class vertex_board;
    vtx_t   pending[$];
    int     mismatches;
    int     steps;
    longint atan_tab[24];
    int unsigned r_outer, r_inner, height, slices, stacks;

    function new(int cordic_steps);
      atan_tab = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
      steps = cordic_steps;
      mismatches = 0;
      r_outer = 256; r_inner = 128; height = 512; slices = 16; stacks = 8;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_OUTER_RADIUS: r_outer = data;
        REG_INNER_RADIUS: r_inner = data;
        REG_TUBE_HEIGHT:  height  = data;
        REG_SLICE_COUNT:  slices  = data[10:0];
        REG_STACK_COUNT:  stacks  = data[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned divisions(int unsigned c);
      if (c == 0) return 1;
      if (c > 1024) return 1024;
      return c;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function angle_t angle_of(int unsigned k, int unsigned s);
      longint unsigned ph64;
      bit [31:0] ph;
      bit flip;
      longint x, y, z, dx, dy;
      angle_t a;
      ph64 = ((longint'(k) << 32) + (s >> 1)) / s;
      ph = ph64[31:0];
      flip = 0;
      x = 652032874; y = 0;
      if (ph >= 32'h40000000 && ph < 32'hC0000000) begin
        ph = ph - 32'h80000000;
        flip = 1;
      end
      z = longint'($signed(ph));
      for (int i = 0; i < steps && i < 24; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      a.c30 = x; a.s30 = y;
      a.c14 = clip((x + 64'sd32768) >>> 16, -16384, 16384);
      a.s14 = clip((y + 64'sd32768) >>> 16, -16384, 16384);
      return a;
    endfunction

    function longint scaled(int unsigned r, longint v30);
      return clip((longint'(r) * v30 + (64'sd1 << 29)) >>> 30, -32768, 32767);
    endfunction

    function longint level(int unsigned k, int unsigned st);
      longint n, d, m, q;
      n = longint'(height) * (longint'(st) - 2 * longint'(k));
      d = 2 * longint'(st);
      m = n < 0 ? -n : n;
      q = (2 * m + d) / (2 * d);
      return clip(n < 0 ? -q : q, -32768, 32767);
    endfunction

    function void push(int unsigned r, angle_t a, longint y, longint nx, longint ny,
                       longint nz, longint u, longint v);
      vtx_t t;
      t.pos_x = scaled(r, a.s30);
      t.pos_y = y;
      t.pos_z = scaled(r, a.c30);
      t.norm_x = nx;
      t.norm_y = ny;
      t.norm_z = nz;
      t.tex_u = u;
      t.tex_v = v;
      t.last_vertex = 0;
      pending.push_back(t);
    endfunction

    function void note_cell(in_item_t c);
      int unsigned s, st, ring, ro, ri;
      angle_t a0, a1;
      longint y, ylo, yhi;
      s = divisions(slices); st = divisions(stacks);
      ring = c.ring_index; ro = r_outer; ri = r_inner;
      if (ring > st + 1) return;
      a0 = angle_of(c.slice_index, s);
      a1 = angle_of(c.slice_index + 1, s);
      if (ring == 0) begin
        y = level(0, st);
        push(ri, a1, y, 0, 16384, 0, 0, 16384);
        push(ri, a0, y, 0, 16384, 0, 0, 0);
        push(ro, a0, y, 0, 16384, 0, 16384, 0);
        push(ro, a0, y, 0, 16384, 0, 16384, 0);
        push(ro, a1, y, 0, 16384, 0, 16384, 16384);
        push(ri, a1, y, 0, 16384, 0, 0, 16384);
      end else if (ring == st + 1) begin
        y = level(st, st);
        push(ro, a0, y, 0, -16384, 0, 16384, 0);
        push(ri, a0, y, 0, -16384, 0, 0, 0);
        push(ri, a1, y, 0, -16384, 0, 0, 16384);
        push(ri, a1, y, 0, -16384, 0, 0, 16384);
        push(ro, a1, y, 0, -16384, 0, 16384, 16384);
        push(ro, a0, y, 0, -16384, 0, 16384, 0);
      end else begin
        ylo = level(ring, st);
        yhi = level(ring - 1, st);
        push(ro, a1, yhi, a1.s14, 0, a1.c14, 0, 0);
        push(ro, a0, yhi, a0.s14, 0, a0.c14, 0, 0);
        push(ro, a0, ylo, a0.s14, 0, a0.c14, 0, 0);
        push(ro, a1, yhi, a1.s14, 0, a1.c14, 0, 0);
        push(ro, a0, ylo, a0.s14, 0, a0.c14, 0, 0);
        push(ro, a1, ylo, a1.s14, 0, a1.c14, 0, 0);
        push(ri, a0, ylo, -a0.s14, 0, -a0.c14, 0, 0);
        push(ri, a0, yhi, -a0.s14, 0, -a0.c14, 0, 0);
        push(ri, a1, yhi, -a1.s14, 0, -a1.c14, 0, 0);
        push(ri, a1, ylo, -a1.s14, 0, -a1.c14, 0, 0);
        push(ri, a0, ylo, -a0.s14, 0, -a0.c14, 0, 0);
        push(ri, a1, yhi, -a1.s14, 0, -a1.c14, 0, 0);
      end
      pending[pending.size() - 1].last_vertex = 1;
    endfunction

    function void check_vertex(vtx_t got);
      vtx_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.pos_z !== want.pos_z || got.norm_x !== want.norm_x ||
          got.norm_y !== want.norm_y || got.norm_z !== want.norm_z ||
          got.tex_u !== want.tex_u || got.tex_v !== want.tex_v ||
          got.last_vertex !== want.last_vertex) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
      end
    endfunction
  endclass

  localparam int LATENCY = 63 + 16 + 3;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  bit          calm = 0;
  int          stall_left = 0;

  tmt_stream_if #(.T(in_item_t)) cells ();
  tmt_stream_if #(.T(vtx_t))     verts ();

  tube_mesh_tessellator dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cells(cells.sink), .verts(verts.source)
  );

  vertex_board board = new(16);

  always #5 clk = ~clk;

  initial begin
    cells.valid = 0;
    cells.payload = '0;
    verts.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (verts.valid && verts.ready) board.check_vertex(verts.payload);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        verts.ready <= 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        stall_left <= $urandom_range(0, 6);
        verts.ready <= 0;
      end else begin
        verts.ready <= 1;
      end
    end
  end

  task automatic send_cell(int unsigned ring, int unsigned slice);
    in_item_t c;
    c.ring_index = ring;
    c.slice_index = slice;
    if (!calm && $urandom_range(3) == 0) begin
      cells.valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cells.valid <= 1;
    cells.payload <= c;
    do @(posedge clk); while (!cells.ready);
    board.note_cell(c);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned data);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.write_reg(idx, data);
  endtask

  task automatic drain();
    cells.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic configure(int unsigned ro, int unsigned ri, int unsigned h,
                           int unsigned s, int unsigned st);
    drain();
    write_reg(REG_OUTER_RADIUS, ro);
    write_reg(REG_INNER_RADIUS, ri);
    write_reg(REG_TUBE_HEIGHT, h);
    write_reg(REG_SLICE_COUNT, s);
    write_reg(REG_STACK_COUNT, st);
  endtask

  task automatic random_cells(int n);
    int unsigned s, st, ring;
    s = board.divisions(board.slices);
    st = board.divisions(board.stacks);
    repeat (n) begin
      if ($urandom_range(9) == 0) ring = $urandom_range(st + 2, 2047);
      else ring = $urandom_range(0, st + 1);
      send_cell(ring, $urandom_range(1) ? $urandom_range(0, s - 1) : $urandom_range(0, 1023));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(8, 15);
    send_cell(9, 15);
    send_cell(10, 3);
    send_cell(2047, 1023);
    send_cell(0, 1023);
    send_cell(5, 16);
    send_cell(9, 1023);

    configure(65535, 0, 65535, 0, 0);
    send_cell(0, 0);
    send_cell(1, 1023);
    send_cell(2, 0);
    send_cell(3, 5);

    configure(0, 65535, 0, 1024, 1024);
    send_cell(0, 1023);
    send_cell(1, 512);
    send_cell(1024, 0);
    send_cell(1025, 1023);
    send_cell(1026, 7);

    configure(1000, 300, 777, 2047, 2047);
    send_cell(1025, 1023);
    send_cell(300, 100);

    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535),
                $urandom_range(3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 32),
                $urandom_range(3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 16));
      if (p == 3) calm = 1;
      random_cells(75);
    end

    drain();
    if (board.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
